>>> rtl/core/locator_distance_engine_assert.svh
// Assertion macros for the locator distance engine.
`ifndef LOCATOR_DISTANCE_ENGINE_ASSERT_SVH
`define LOCATOR_DISTANCE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define LDE_ASSERT_CLK(name, clk_s, rst_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define LDE_ASSERT(name, prop, msg) \
  `LDE_ASSERT_CLK(name, clk, rst, prop, msg)
`else
`define LDE_ASSERT_CLK(name, clk_s, rst_s, prop, msg)
`define LDE_ASSERT(name, prop, msg)
`endif

`endif

>>> rtl/core/lde_pkg.sv
package lde_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_HOME_LAT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_LON = 4'd1;

  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_UR     = 8'h52;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CASE_OFFS = 8'd32;

  localparam logic signed [16:0] LAT_MAX = 17'sd43200;
  localparam logic signed [17:0] LON_MAX = 18'sd86400;

  // angle lanes: two half angles, two full latitudes
  localparam int L_DLAT = 0;
  localparam int L_DLON = 1;
  localparam int L_LAT  = 2;
  localparam int L_HLAT = 3;
  localparam int LANES  = 4;

  localparam logic [15:0] RAD_Q   [LANES] = '{16'd19521, 16'd19521, 16'd39042, 16'd39042};
  localparam logic [18:0] RAD_RND [LANES] = '{19'd345600, 19'd345600, 19'd172800, 19'd172800};
  localparam logic [3:0]  RAD_SH  [LANES] = '{4'd10, 4'd10, 4'd9, 4'd9};
  localparam logic [16:0] RAD_R        = 17'd122505;
  localparam logic [9:0]  RAD_DIV      = 10'd675;
  localparam logic [30:0] RAD_RECIP    = 31'd1628906115;
  localparam int          RAD_RECIP_SH = 40;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h40000000;
  localparam logic [29:0] GAIN_Q30    = 30'h26DD3B6A;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  localparam int          SQRT_STEPS = 31;
  localparam logic [60:0] SQ_ONE     = 61'h1000000000000000;

  localparam logic [13:0] EARTH_KM2 = 14'd12742;
  localparam logic [14:0] MAX_KM    = 15'd20015;

  typedef logic signed [33:0] cw_t;

  typedef struct packed {
    logic              ok;
    logic signed [16:0] lat;
    logic signed [17:0] lon;
  } side_t;

endpackage

>>> rtl/core/locator_distance_engine.sv
// channel | direction | handshake           | payload
// in      | in        | in_valid/in_ready   | char0..char7, length
// out     | out       | out_valid/out_ready | valid_res, centre_lat, centre_lon, distance_km
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// One request per cycle while the output register is not stalled.
// Most of the latency lies in the rotation CORDIC, the 31-stage square root pair and the
// vectoring CORDIC, each one stage per iteration.
// Reset clears all valid bits and the home position; payload stages are not reset.
// When the output register is full and out_ready is low, every stage holds.
`include "locator_distance_engine_assert.svh"

module locator_distance_engine
  import lde_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             char0,
  input  logic [7:0]             char1,
  input  logic [7:0]             char2,
  input  logic [7:0]             char3,
  input  logic [7:0]             char4,
  input  logic [7:0]             char5,
  input  logic [7:0]             char6,
  input  logic [7:0]             char7,
  input  logic [3:0]             length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   valid_res,
  output logic signed [16:0]     centre_lat,
  output logic signed [17:0]     centre_lon,
  output logic [14:0]            distance_km,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  function automatic logic let_ok(input logic [7:0] c, input logic [7:0] last);
    return ((c >= CH_UA) && (c <= last)) || ((c >= CH_LA) && (c <= last + CASE_OFFS));
  endfunction

  function automatic logic [4:0] let_idx(input logic [7:0] c);
    return (c >= CH_LA) ? 5'(c - CH_LA) : 5'(c - CH_UA);
  endfunction

  function automatic logic dig_ok(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] dig_idx(input logic [7:0] c);
    return 4'(c - CH_ZERO);
  endfunction

  function automatic logic [30:0] sat_q30(input cw_t v);
    if (v < 0) return '0;
    else if (v > $signed({3'b000, ONE_Q30})) return ONE_Q30;
    else return v[30:0];
  endfunction

  function automatic logic [30:0] mag_q30(input cw_t v);
    cw_t t;
    t = (v < 0) ? -v : v;
    return sat_q30(t);
  endfunction

  logic en;
  assign en        = out_ready || !out_valid;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  logic signed [16:0] home_lat;
  logic signed [17:0] home_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_lat <= '0;
      home_lon <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOME_LAT: home_lat <= cfg_data[16:0];
        REG_HOME_LON: home_lon <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // decode
  logic               len_ok, dec_ok;
  logic [4:0]         f0, f1, l4, l5;
  logic [3:0]         d2, d3, d6, d7;
  logic [17:0]        lon_u;
  logic [16:0]        lat_u;
  logic [17:0]        lon_off;
  logic [16:0]        lat_off;
  logic signed [18:0] lon_s;
  logic signed [17:0] lat_s;
  logic signed [16:0] hlat_c;
  logic signed [17:0] hlon_c;
  side_t              sd_n;

  always_comb begin
    len_ok = (length == 4'd2) || (length == 4'd4) || (length == 4'd6) || (length == 4'd8);
    dec_ok = len_ok && let_ok(char0, CH_UR) && let_ok(char1, CH_UR);
    if (length >= 4'd4) dec_ok = dec_ok && dig_ok(char2) && dig_ok(char3);
    if (length >= 4'd6) dec_ok = dec_ok && let_ok(char4, CH_UX) && let_ok(char5, CH_UX);
    if (length >= 4'd8) dec_ok = dec_ok && dig_ok(char6) && dig_ok(char7);
    f0 = let_idx(char0);
    f1 = let_idx(char1);
    d2 = (length >= 4'd4) ? dig_idx(char2) : '0;
    d3 = (length >= 4'd4) ? dig_idx(char3) : '0;
    l4 = (length >= 4'd6) ? let_idx(char4) : '0;
    l5 = (length >= 4'd6) ? let_idx(char5) : '0;
    d6 = (length >= 4'd8) ? dig_idx(char6) : '0;
    d7 = (length >= 4'd8) ? dig_idx(char7) : '0;
    case (length)
      4'd2: begin
        lon_off = 18'd4800;
        lat_off = 17'd2400;
      end
      4'd4: begin
        lon_off = 18'd480;
        lat_off = 17'd240;
      end
      4'd6: begin
        lon_off = 18'd20;
        lat_off = 17'd10;
      end
      default: begin
        lon_off = 18'd2;
        lat_off = 17'd1;
      end
    endcase
    lon_u = 18'(f0) * 18'd9600 + 18'(d2) * 18'd960 + 18'(l4) * 18'd40 + 18'(d6) * 18'd4
            + lon_off;
    lat_u = 17'(f1) * 17'd4800 + 17'(d3) * 17'd480 + 17'(l5) * 17'd20 + 17'(d7) * 17'd2
            + lat_off;
    lon_s = $signed({1'b0, lon_u}) - 19'sd86400;
    lat_s = $signed({1'b0, lat_u}) - 18'sd43200;
    sd_n.ok  = dec_ok;
    sd_n.lat = 17'(lat_s);
    sd_n.lon = 18'(lon_s);
    if (home_lat > LAT_MAX) hlat_c = LAT_MAX;
    else if (home_lat < -LAT_MAX) hlat_c = -LAT_MAX;
    else hlat_c = home_lat;
    if (home_lon > LON_MAX) hlon_c = LON_MAX;
    else if (home_lon < -LON_MAX) hlon_c = -LON_MAX;
    else hlon_c = home_lon;
  end

  // angle setup stages
  logic               v1, v2, v3, v4, v5, v6;
  side_t              sd1, sd2, sd3, sd4, sd5, sd6;
  logic signed [16:0] hlat1;
  logic signed [17:0] hlon1;
  logic [17:0]        m2_n [LANES];
  logic [17:0]        m2   [LANES];
  logic [31:0]        hi_n [LANES];
  logic [31:0]        hi3  [LANES];
  logic [31:0]        hi4  [LANES];
  logic [31:0]        hi5  [LANES];
  logic [24:0]        xq_n [LANES];
  logic [24:0]        xq3  [LANES];
  logic [24:0]        xq4  [LANES];
  logic [15:0]        qa_n [LANES];
  logic [15:0]        qa4  [LANES];
  logic [15:0]        qf_n [LANES];
  logic [15:0]        qf5  [LANES];
  logic [31:0]        ang6 [LANES];
  logic [24:0]        rem  [LANES];
  logic [17:0]        dlat;
  logic [18:0]        dlon;
  logic [17:0]        lat_e, hlat_e;

  always_comb begin
    dlat   = {sd1.lat[16], sd1.lat} - {hlat1[16], hlat1};
    dlon   = {sd1.lon[17], sd1.lon} - {hlon1[17], hlon1};
    lat_e  = {sd1.lat[16], sd1.lat};
    hlat_e = {hlat1[16], hlat1};
    m2_n[L_DLAT] = dlat[17] ? -dlat : dlat;
    m2_n[L_DLON] = dlon[18] ? 18'(-dlon) : 18'(dlon);
    m2_n[L_LAT]  = lat_e[17] ? -lat_e : lat_e;
    m2_n[L_HLAT] = hlat_e[17] ? -hlat_e : hlat_e;
    for (int i = 0; i < LANES; i++) begin
      hi_n[i] = 32'(34'(m2[i]) * 34'(RAD_Q[i]));
      xq_n[i] = 25'((36'(m2[i]) * 36'(RAD_R) + 36'(RAD_RND[i])) >> RAD_SH[i]);
      qa_n[i] = 16'((57'(xq3[i]) * 57'(RAD_RECIP)) >> RAD_RECIP_SH);
      rem[i]  = xq4[i] - 25'(25'(qa4[i]) * 25'(RAD_DIV));
      qf_n[i] = qa4[i] + 16'(rem[i] >= 25'(RAD_DIV));
    end
  end

  // rotation CORDIC lanes
  cw_t   rx [0:CORDIC_STEPS][LANES];
  cw_t   ry [0:CORDIC_STEPS][LANES];
  cw_t   rz [0:CORDIC_STEPS][LANES];
  logic  rv [0:CORDIC_STEPS];
  side_t rsd [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      v6    <= 1'b0;
      rv[0] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      rv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1    <= sd_n;
      hlat1  <= hlat_c;
      hlon1  <= hlon_c;
      sd2    <= sd1;
      sd3    <= sd2;
      sd4    <= sd3;
      sd5    <= sd4;
      sd6    <= sd5;
      rsd[0] <= sd6;
      m2     <= m2_n;
      hi3    <= hi_n;
      xq3    <= xq_n;
      hi4    <= hi3;
      xq4    <= xq3;
      qa4    <= qa_n;
      hi5    <= hi4;
      qf5    <= qf_n;
      for (int i = 0; i < LANES; i++) begin
        ang6[i]  <= hi5[i] + 32'(qf5[i]);
        rx[0][i] <= $signed(34'(GAIN_Q30));
        ry[0][i] <= '0;
        if ((i == L_DLON) && (ang6[i] > HALF_PI_Q30)) begin
          rz[0][i] <= $signed(34'(PI_Q30 - ang6[i]));
        end else begin
          rz[0][i] <= $signed(34'(ang6[i]));
        end
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (en) begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rsd[k+1] <= rsd[k];
        for (int i = 0; i < LANES; i++) begin
          if (rz[k][i] >= 0) begin
            rx[k+1][i] <= rx[k][i] - (ry[k][i] >>> k);
            ry[k+1][i] <= ry[k][i] + (rx[k][i] >>> k);
            rz[k+1][i] <= rz[k][i] - $signed(34'(ATAN_Q30[k]));
          end else begin
            rx[k+1][i] <= rx[k][i] + (ry[k][i] >>> k);
            ry[k+1][i] <= ry[k][i] - (rx[k][i] >>> k);
            rz[k+1][i] <= rz[k][i] + $signed(34'(ATAN_Q30[k]));
          end
        end
      end
    end
  end

  // haversine term
  logic        vc, vm1, vm2, vm3;
  side_t       sdc, sdm1, sdm2, sdm3;
  logic [30:0] s1c, s2c, clc, chc;
  logic [30:0] p1, p2, s2m1, s2m2;
  logic [60:0] ss1m1, ss1m2, ss1m3, p3;
  logic [61:0] a_sum;
  logic [60:0] a_sat;

  logic [60:0] sn [0:SQRT_STEPS][2];
  logic [61:0] sr [0:SQRT_STEPS][2];
  logic        qv [0:SQRT_STEPS];
  side_t       qsd [0:SQRT_STEPS];

  always_comb begin
    a_sum = 62'(ss1m3) + 62'(p3);
    a_sat = (a_sum > 62'(SQ_ONE)) ? SQ_ONE : a_sum[60:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc    <= 1'b0;
      vm1   <= 1'b0;
      vm2   <= 1'b0;
      vm3   <= 1'b0;
      qv[0] <= 1'b0;
    end else if (en) begin
      vc    <= rv[CORDIC_STEPS];
      vm1   <= vc;
      vm2   <= vm1;
      vm3   <= vm2;
      qv[0] <= vm3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdc      <= rsd[CORDIC_STEPS];
      s1c      <= mag_q30(ry[CORDIC_STEPS][L_DLAT]);
      s2c      <= mag_q30(ry[CORDIC_STEPS][L_DLON]);
      clc      <= sat_q30(rx[CORDIC_STEPS][L_LAT]);
      chc      <= sat_q30(rx[CORDIC_STEPS][L_HLAT]);
      sdm1     <= sdc;
      p1       <= 31'((62'(clc) * 62'(chc)) >> 30);
      ss1m1    <= 61'(62'(s1c) * 62'(s1c));
      s2m1     <= s2c;
      sdm2     <= sdm1;
      p2       <= 31'((62'(p1) * 62'(s2m1)) >> 30);
      ss1m2    <= ss1m1;
      s2m2     <= s2m1;
      sdm3     <= sdm2;
      p3       <= 61'(62'(p2) * 62'(s2m2));
      ss1m3    <= ss1m2;
      qsd[0]   <= sdm3;
      sn[0][0] <= a_sat;
      sn[0][1] <= SQ_ONE - a_sat;
      sr[0][0] <= '0;
      sr[0][1] <= '0;
    end
  end

  // square roots of a and 1-a, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] SQ_BIT = 63'(1) << (60 - 2 * k);
    logic [62:0] trial [2];

    always_comb begin
      for (int j = 0; j < 2; j++) begin
        trial[j] = {1'b0, sr[k][j]} + SQ_BIT;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (en) begin
        qv[k+1] <= qv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qsd[k+1] <= qsd[k];
        for (int j = 0; j < 2; j++) begin
          if ({2'b00, sn[k][j]} >= trial[j]) begin
            sn[k+1][j] <= 61'({2'b00, sn[k][j]} - trial[j]);
            sr[k+1][j] <= (sr[k][j] >> 1) + 62'(SQ_BIT);
          end else begin
            sn[k+1][j] <= sn[k][j];
            sr[k+1][j] <= sr[k][j] >> 1;
          end
        end
      end
    end
  end

  // vectoring CORDIC
  cw_t   vx [0:CORDIC_STEPS];
  cw_t   vy [0:CORDIC_STEPS];
  cw_t   vz [0:CORDIC_STEPS];
  logic  vv [0:CORDIC_STEPS];
  side_t vsd [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= qv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vsd[0] <= qsd[SQRT_STEPS];
      vx[0]  <= $signed(34'(sr[SQRT_STEPS][1]));
      vy[0]  <= $signed(34'(sr[SQRT_STEPS][0]));
      vz[0]  <= '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else if (en) begin
        vv[k+1] <= vv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vsd[k+1] <= vsd[k];
        if (vy[k] >= 0) begin
          vx[k+1] <= vx[k] + (vy[k] >>> k);
          vy[k+1] <= vy[k] - (vx[k] >>> k);
          vz[k+1] <= vz[k] + $signed(34'(ATAN_Q30[k]));
        end else begin
          vx[k+1] <= vx[k] - (vy[k] >>> k);
          vy[k+1] <= vy[k] + (vx[k] >>> k);
          vz[k+1] <= vz[k] - $signed(34'(ATAN_Q30[k]));
        end
      end
    end
  end

  // distance and output register
  logic        vf;
  side_t       sdf;
  logic [15:0] distf;
  logic [32:0] zc;

  assign zc = (vz[CORDIC_STEPS] < 0) ? '0 : vz[CORDIC_STEPS][32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vf        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vf        <= vv[CORDIC_STEPS];
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdf        <= vsd[CORDIC_STEPS];
      distf      <= 16'((48'(zc) * 48'(EARTH_KM2)) >> 30);
      valid_res  <= sdf.ok;
      centre_lat <= sdf.ok ? sdf.lat : '0;
      centre_lon <= sdf.ok ? sdf.lon : '0;
      if (!sdf.ok) begin
        distance_km <= '0;
      end else if (distf > 16'(MAX_KM)) begin
        distance_km <= MAX_KM;
      end else begin
        distance_km <= distf[14:0];
      end
    end
  end

  `LDE_ASSERT(a_in_enters, (in_valid && in_ready) |=> v1, "accepted request missing in first stage")
  `LDE_ASSERT(a_invalid_zero, (out_valid && !valid_res) |-> (centre_lat == 0 && centre_lon == 0 && distance_km == 0), "invalid locator with nonzero result")
  `LDE_ASSERT(a_dist_max, out_valid |-> (distance_km <= MAX_KM), "distance above limit")
  `LDE_ASSERT_CLK(a_sqrt_bound, clk, rst, qv[SQRT_STEPS] |-> (sr[SQRT_STEPS][0] <= 62'(ONE_Q30) && sr[SQRT_STEPS][1] <= 62'(ONE_Q30)), "square root out of range")

endmodule

>>> bench/tb.sv
module tb;
  import lde_pkg::*;

  localparam int                     STEPS        = 24;
  localparam longint unsigned        PI_Q32       = 64'd13493037705;
  localparam longint                 Q30          = 64'sd1073741824;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd9;
  localparam int                     IDLE_PCT     = 37;
  localparam int                     STALL_LIMIT  = 20000;

  typedef struct packed {
    logic [0:7][7:0] ch;
    logic [3:0]      len;
  } loc_t;

  typedef struct packed {
    logic               ok;
    logic signed [16:0] lat;
    logic signed [17:0] lon;
    logic [14:0]        km;
  } fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char0 = '0, char1 = '0, char2 = '0, char3 = '0;
  logic [7:0] char4 = '0, char5 = '0, char6 = '0, char7 = '0;
  logic [3:0] length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_res;
  logic signed [16:0] centre_lat;
  logic signed [17:0] centre_lon;
  logic [14:0] distance_km;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [16:0] home_lat_reg = '0;
  logic [17:0] home_lon_reg = '0;
  fix_t fixes_due[$];
  int errors = 0;
  int stall_cycles = 0;
  bit idling = 1'b1;

  locator_distance_engine u_top (.*);

  always #4 clk = ~clk;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint angle_q30(longint u, longint unsigned div);
    longint unsigned m;
    m = u < 0 ? -u : u;
    return longint'((m * PI_Q32 + div / 2) / div);
  endfunction

  function automatic void rotate(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    c = clampl(x, 0, Q30);
    s = clampl(y < 0 ? -y : y, 0, Q30);
  endfunction

  function automatic longint arctan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit letter_idx(logic [7:0] c, logic [7:0] last, output longint idx);
    idx = 0;
    if (c >= CH_UA && c <= last) begin
      idx = longint'(c) - longint'(CH_UA); return 1'b1;
    end
    if (c >= CH_LA && c <= last + CASE_OFFS) begin
      idx = longint'(c) - longint'(CH_LA); return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit digit_idx(logic [7:0] c, output longint idx);
    idx = 0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      idx = longint'(c) - longint'(CH_ZERO); return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic fix_t locate_fix(loc_t it);
    fix_t r;
    bit ok;
    longint f0, f1, d2, d3, l4, l5, d6, d7, lat, lon, hlat, hlon;
    longint s1, s2, cl, ch, tmp, z;
    longint unsigned p, a, y, x, km;
    f0 = 0; f1 = 0; d2 = 0; d3 = 0; l4 = 0; l5 = 0; d6 = 0; d7 = 0;
    r = '0;
    ok = it.len inside {4'd2, 4'd4, 4'd6, 4'd8};
    if (ok) ok = letter_idx(it.ch[0], CH_UR, f0) && letter_idx(it.ch[1], CH_UR, f1);
    if (ok && it.len >= 4) ok = digit_idx(it.ch[2], d2) && digit_idx(it.ch[3], d3);
    if (ok && it.len >= 6)
      ok = letter_idx(it.ch[4], CH_UX, l4) && letter_idx(it.ch[5], CH_UX, l5);
    if (ok && it.len >= 8) ok = digit_idx(it.ch[6], d6) && digit_idx(it.ch[7], d7);
    if (!ok) return r;
    lon = -86400 + f0 * 9600 + d2 * 960 + l4 * 40 + d6 * 4;
    lat = -43200 + f1 * 4800 + d3 * 480 + l5 * 20 + d7 * 2;
    case (it.len)
      4'd2: begin lon += 4800; lat += 2400; end
      4'd4: begin lon += 480; lat += 240; end
      4'd6: begin lon += 20; lat += 10; end
      default: begin lon += 2; lat += 1; end
    endcase
    hlat = clampl(longint'(signed'(home_lat_reg)), -43200, 43200);
    hlon = clampl(longint'(signed'(home_lon_reg)), -86400, 86400);
    rotate(angle_q30(lat - hlat, 691200), tmp, s1);
    z = angle_q30(lon - hlon, 691200);
    if (z > longint'(HALF_PI_Q30)) z = longint'(PI_Q30) - z;
    rotate(z, tmp, s2);
    rotate(angle_q30(lat, 345600), cl, tmp);
    rotate(angle_q30(hlat, 345600), ch, tmp);
    p = (longint'(cl) * longint'(ch)) >> 30;
    p = ((p * s2) >> 30) * s2;
    a = s1 * s1 + p;
    if (a > (64'd1 << 60)) a = 64'd1 << 60;
    y = int_sqrt(a);
    x = int_sqrt((64'd1 << 60) - a);
    z = arctan2(longint'(y), longint'(x));
    km = (z * 2 * 6371) >> 30;
    if (km > 64'(MAX_KM)) km = 64'(MAX_KM);
    r.ok = 1'b1;
    r.lat = lat[16:0];
    r.lon = lon[17:0];
    r.km = km[14:0];
    return r;
  endfunction

  always @(negedge clk) out_ready = idling ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    fix_t e;
    if (!rst && out_valid && out_ready) begin
      if (fixes_due.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = fixes_due.pop_front();
        if (valid_res !== e.ok) begin
          $error("valid_res exp %0d got %0d", e.ok, valid_res); errors++;
        end
        if (centre_lat !== e.lat) begin
          $error("centre_lat exp %0d got %0d", e.lat, centre_lat); errors++;
        end
        if (centre_lon !== e.lon) begin
          $error("centre_lon exp %0d got %0d", e.lon, centre_lon); errors++;
        end
        if (distance_km !== e.km) begin
          $error("distance_km exp %0d got %0d", e.km, distance_km); errors++;
        end
      end
    end
  end

  task automatic send_locator(loc_t it);
    while (idling && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {char0, char1, char2, char3, char4, char5, char6, char7} = it.ch;
    length = it.len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fixes_due.push_back(locate_fix(it));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (fixes_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HOME_LAT) home_lat_reg = data[16:0];
    else if (idx == REG_HOME_LON) home_lon_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_home(logic [CFG_DATA_W-1:0] lat, logic [CFG_DATA_W-1:0] lon);
    drain();
    write_reg(REG_HOME_LAT, lat);
    write_reg(REG_HOME_LON, lon);
  endtask

  function automatic loc_t from_text(string s);
    loc_t it;
    for (int i = 0; i < 8; i++) it.ch[i] = i < s.len() ? s[i] : 8'($urandom);
    it.len = 4'(s.len());
    return it;
  endfunction

  function automatic loc_t random_locator();
    loc_t it;
    int n;
    n = 2 * $urandom_range(1, 4);
    for (int i = 0; i < 8; i++) begin
      it.ch[i] = 8'($urandom);
      if (i < n) begin
        if (i == 2 || i == 3 || i == 6 || i == 7)
          it.ch[i] = 8'(CH_ZERO + $urandom_range(9));
        else
          it.ch[i] = 8'(($urandom_range(1) ? CH_UA : CH_LA)
                        + $urandom_range(i < 2 ? 17 : 23));
      end
    end
    it.len = 4'(n);
    return it;
  endfunction

  function automatic loc_t noisy_locator();
    loc_t it;
    it = random_locator();
    case ($urandom_range(2))
      0: it.ch[3'($urandom_range(it.len - 1))] = 8'($urandom);
      1: it.len = 4'($urandom);
      default: begin
        it.ch = 64'({$urandom, $urandom});
        it.len = 4'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++)
      send_locator($urandom_range(99) < 80 ? random_locator() : noisy_locator());
  endtask

  task automatic test_directed();
    loc_t it;
    send_locator(from_text("AA"));
    send_locator(from_text("RR"));
    send_locator(from_text("ar"));
    send_locator(from_text("JN58"));
    send_locator(from_text("JO62qm"));
    send_locator(from_text("AA00aa00"));
    send_locator(from_text("RR99XX99"));
    send_locator(from_text("rr99xx99"));
    send_locator(from_text("Ra09Xa90"));
    send_locator(from_text("SA"));
    send_locator(from_text("@A"));
    send_locator(from_text("Ar"));
    send_locator(from_text("as"));
    send_locator(from_text("AA:0"));
    send_locator(from_text("AA0/"));
    send_locator(from_text("AA00YA"));
    send_locator(from_text("AA00ay"));
    send_locator(from_text("AA00AA0:"));
    for (int l = 0; l < 16; l += 3) begin
      it = from_text("JN58td25");
      it.len = 4'(l);
      send_locator(it);
    end
    it = from_text("JN58td25");
    it.len = 4'd15;
    send_locator(it);
  endtask

  task automatic test_home_extremes();
    set_home(18'(-43200), 18'(-86400));
    run_random(150);
    set_home(18'd43200, 18'd86400);
    run_random(150);
    set_home(18'h0FFFF, 18'h1FFFF);
    run_random(120);
    set_home(18'h10000, 18'h20000);
    run_random(120);
  endtask

  task automatic test_unmapped_index();
    set_home(18'(-1234), 18'd55555);
    write_reg(REG_UNMAPPED, 18'h3FFFF);
    run_random(150);
  endtask

  task automatic test_random_homes();
    for (int k = 0; k < 4; k++) begin
      set_home(18'($urandom_range(0, 86400) - 43200), 18'($urandom_range(0, 172800) - 86400));
      run_random(105);
    end
  endtask

  task automatic test_back_to_back();
    idling = 1'b0;
    run_random(200);
    idling = 1'b1;
  endtask

  task automatic test_pause_then_burst();
    run_random(60);
    while (fixes_due.size() != 0) @(negedge clk);
    run_random(60);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_home_extremes();
    test_unmapped_index();
    test_random_homes();
    test_back_to_back();
    test_pause_then_burst();
    while (fixes_due.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
